// ----- src/cfp_pkg.sv -----
// Shared types and constants of the closest and farthest pair finder.
`timescale 1ns / 1ps

package cfp_pkg;

   // Defaults for the top level parameters
   localparam int MAX_POINTS_DEF  = 256;
   localparam int COORD_BITS_DEF  = 16;

   // Fixed port widths
   localparam int IN_COORD_W  = 16;
   localparam int OUT_COORD_W = 16;
   localparam int DIST_OUT_W  = 33;
   localparam int STATUS_W    = 2;

   // Width used for explicit sign and zero extension before truncation
   localparam int WIDE_W = 64;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // What the back does with a point
   typedef enum logic {
      KIND_STORE = 1'b0,
      KIND_DROP  = 1'b1
   } kind_type;

   // Result status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_FEW  = 2'd1;
   localparam status_type STATUS_DROP = 2'd2;

   // Classification of one request, handed from front to back
   typedef struct packed {
      kind_type kind;
      logic     last;
      logic     dropped;
   } item_ctrl_type;

endpackage

// ----- src/cfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/cfp_queue.sv -----
// Small register FIFO between the front and the back.
`timescale 1ns / 1ps

module cfp_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/cfp_front.sv -----
// Front: takes requests, trims coordinates, assigns store slots and flags drops.
`timescale 1ns / 1ps

module cfp_front #(
   parameter int MAX_POINTS = cfp_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = cfp_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [cfp_pkg::IN_COORD_W-1:0] req_coord_x,
   input  logic signed [cfp_pkg::IN_COORD_W-1:0] req_coord_y,
   input  logic                                  req_last_point,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output cfp_pkg::item_ctrl_type                push_ctrl,
   output logic [$clog2(MAX_POINTS)-1:0]         push_idx,
   output logic [COORD_BITS-1:0]                 push_x,
   output logic [COORD_BITS-1:0]                 push_y
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         dropped_ff, dropped_in;
   logic                         room;
   logic                         accept;
   logic [cfp_pkg::WIDE_W-1:0]   wide_x, wide_y;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign room       = (count_ff < CNT_MAX);

   // Coordinates are the low COORD_BITS of the raw field
   assign wide_x = {{(cfp_pkg::WIDE_W - cfp_pkg::IN_COORD_W){1'b0}}, req_coord_x};
   assign wide_y = {{(cfp_pkg::WIDE_W - cfp_pkg::IN_COORD_W){1'b0}}, req_coord_y};
   assign push_x = wide_x[COORD_BITS-1:0];
   assign push_y = wide_y[COORD_BITS-1:0];

   // Classification
   assign push_idx          = count_ff[IDX_W-1:0];
   assign push_ctrl.kind    = room ? cfp_pkg::KIND_STORE : cfp_pkg::KIND_DROP;
   assign push_ctrl.last    = req_last_point;
   assign push_ctrl.dropped = dropped_ff || !room;

   // Fill count and drop flag of the current set
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         if (req_last_point) begin
            count_in   = '0;
            dropped_in = 1'b0;
         end else if (room) begin
            count_in = count_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

// ----- src/cfp_back.sv -----
// Back: stores each point and runs it against all earlier points through one distance pipe.
`timescale 1ns / 1ps

module cfp_back #(
   parameter int MAX_POINTS = cfp_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = cfp_pkg::COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_valid,
   output logic                                    q_ready,
   input  cfp_pkg::item_ctrl_type                  q_ctrl,
   input  logic [$clog2(MAX_POINTS)-1:0]           q_idx,
   input  logic [COORD_BITS-1:0]                   q_x,
   input  logic [COORD_BITS-1:0]                   q_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [cfp_pkg::DIST_OUT_W-1:0]          rsp_far_dist_sq,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_far_ax,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_far_ay,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_far_bx,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_far_by,
   output logic [cfp_pkg::DIST_OUT_W-1:0]          rsp_near_dist_sq,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_near_ax,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_near_ay,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_near_bx,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0]  rsp_near_by,
   output cfp_pkg::status_type                     rsp_status
);

   localparam int CB     = COORD_BITS;
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int SQ_W   = 2 * CB;
   localparam int DIST_W = SQ_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   function automatic logic [cfp_pkg::OUT_COORD_W-1:0] coord_out(input logic [CB-1:0] v);
      logic [cfp_pkg::WIDE_W-1:0] w;
      w = {{(cfp_pkg::WIDE_W - CB){v[CB-1]}}, v};
      return w[cfp_pkg::OUT_COORD_W-1:0];
   endfunction

   function automatic logic [cfp_pkg::DIST_OUT_W-1:0] dist_out(input logic [DIST_W-1:0] v);
      logic [cfp_pkg::WIDE_W-1:0] w;
      w = {{(cfp_pkg::WIDE_W - DIST_W){1'b0}}, v};
      return w[cfp_pkg::DIST_OUT_W-1:0];
   endfunction

   // Control state
   state_type        state_ff;
   logic [IDX_W-1:0] rd_ff;
   logic [IDX_W-1:0] j_ff;
   logic [IDX_W-1:0] j_last;
   logic [CB-1:0]    px_ff, py_ff;
   logic             last_ff;
   logic             dropped_ff;
   logic             pop;
   logic             pipe_empty;
   logic             load_rsp;

   // Distance pipe
   logic             rdv_ff, s2v_ff, s3v_ff;
   logic [IDX_W-1:0] ri_ff, i2_ff, i3_ff;
   logic [2*CB-1:0]  ram_rd_data;
   logic [CB-1:0]    rqx, rqy;
   logic [CB:0]      dx, dy, dxn, dyn;
   logic [CB-1:0]    ax_in, ay_in;
   logic [CB-1:0]    ax_ff, ay_ff, qx2_ff, qy2_ff, qx3_ff, qy3_ff;
   logic [SQ_W-1:0]  sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [DIST_W-1:0] dist_sq;

   // Best pairs so far
   logic              have_pair_ff;
   logic              take_far, take_near;
   logic [DIST_W-1:0] fd_ff, nd_ff;
   logic [IDX_W-1:0]  fa_ff, na_ff;
   logic [CB-1:0]     fax_ff, fay_ff, fbx_ff, fby_ff;
   logic [CB-1:0]     nax_ff, nay_ff, nbx_ff, nby_ff;

   // Result register
   logic                                  rsp_valid_ff;
   logic [cfp_pkg::DIST_OUT_W-1:0]        rsp_far_dist_ff, rsp_near_dist_ff;
   logic [cfp_pkg::OUT_COORD_W-1:0]       rsp_far_ax_ff, rsp_far_ay_ff;
   logic [cfp_pkg::OUT_COORD_W-1:0]       rsp_far_bx_ff, rsp_far_by_ff;
   logic [cfp_pkg::OUT_COORD_W-1:0]       rsp_near_ax_ff, rsp_near_ay_ff;
   logic [cfp_pkg::OUT_COORD_W-1:0]       rsp_near_bx_ff, rsp_near_by_ff;
   cfp_pkg::status_type                   rsp_status_ff;

   assign pop        = (state_ff == ST_IDLE) && q_valid;
   assign q_ready    = (state_ff == ST_IDLE);
   assign j_last     = j_ff - 1'b1;
   assign pipe_empty = !rdv_ff && !s2v_ff && !s3v_ff;
   assign load_rsp   = (state_ff == ST_DRAIN) && pipe_empty && last_ff;

   // Point store: write on arrival, read one earlier point a cycle during the sweep
   cfp_ram #(
      .WIDTH (2 * CB),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (pop && (q_ctrl.kind == cfp_pkg::KIND_STORE)),
      .wr_addr (q_idx),
      .wr_data ({q_x, q_y}),
      .rd_addr (rd_ff),
      .rd_data (ram_rd_data)
   );

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  px_ff      <= q_x;
                  py_ff      <= q_y;
                  j_ff       <= q_idx;
                  last_ff    <= q_ctrl.last;
                  dropped_ff <= q_ctrl.dropped;
                  rd_ff      <= '0;
                  if ((q_ctrl.kind == cfp_pkg::KIND_STORE) && (q_idx != '0)) begin
                     state_ff <= ST_SWEEP;
                  end else begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_SWEEP: begin
               rd_ff <= rd_ff + 1'b1;
               if (rd_ff == j_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (pipe_empty) begin
                  if (last_ff) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESULT;
                     if (have_pair_ff) begin
                        rsp_far_dist_ff  <= dist_out(fd_ff);
                        rsp_far_ax_ff    <= coord_out(fax_ff);
                        rsp_far_ay_ff    <= coord_out(fay_ff);
                        rsp_far_bx_ff    <= coord_out(fbx_ff);
                        rsp_far_by_ff    <= coord_out(fby_ff);
                        rsp_near_dist_ff <= dist_out(nd_ff);
                        rsp_near_ax_ff   <= coord_out(nax_ff);
                        rsp_near_ay_ff   <= coord_out(nay_ff);
                        rsp_near_bx_ff   <= coord_out(nbx_ff);
                        rsp_near_by_ff   <= coord_out(nby_ff);
                        rsp_status_ff    <= dropped_ff ? cfp_pkg::STATUS_DROP
                                                       : cfp_pkg::STATUS_OK;
                     end else begin
                        rsp_far_dist_ff  <= '0;
                        rsp_far_ax_ff    <= '0;
                        rsp_far_ay_ff    <= '0;
                        rsp_far_bx_ff    <= '0;
                        rsp_far_by_ff    <= '0;
                        rsp_near_dist_ff <= '0;
                        rsp_near_ax_ff   <= '0;
                        rsp_near_ay_ff   <= '0;
                        rsp_near_bx_ff   <= '0;
                        rsp_near_by_ff   <= '0;
                        rsp_status_ff    <= cfp_pkg::STATUS_FEW;
                     end
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_RESULT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
         endcase
      end
   end

   // Stage 2: differences and their magnitudes
   assign rqx    = ram_rd_data[2*CB-1:CB];
   assign rqy    = ram_rd_data[CB-1:0];
   assign dx     = {rqx[CB-1], rqx} - {px_ff[CB-1], px_ff};
   assign dy     = {rqy[CB-1], rqy} - {py_ff[CB-1], py_ff};
   assign dxn    = (~dx) + 1'b1;
   assign dyn    = (~dy) + 1'b1;
   assign ax_in  = dx[CB] ? dxn[CB-1:0] : dx[CB-1:0];
   assign ay_in  = dy[CB] ? dyn[CB-1:0] : dy[CB-1:0];

   // Stage 3: squares
   assign sqx_in = SQ_W'(ax_ff) * SQ_W'(ax_ff);
   assign sqy_in = SQ_W'(ay_ff) * SQ_W'(ay_ff);

   // Update: sum and compare; on equal distance the lower first index wins
   assign dist_sq   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign take_far  = s3v_ff && (!have_pair_ff || (dist_sq > fd_ff) ||
                                 ((dist_sq == fd_ff) && (i3_ff < fa_ff)));
   assign take_near = s3v_ff && (!have_pair_ff || (dist_sq < nd_ff) ||
                                 ((dist_sq == nd_ff) && (i3_ff < na_ff)));

   // Pipe valids and pair-seen flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff       <= 1'b0;
         s2v_ff       <= 1'b0;
         s3v_ff       <= 1'b0;
         have_pair_ff <= 1'b0;
      end else begin
         rdv_ff <= (state_ff == ST_SWEEP);
         s2v_ff <= rdv_ff;
         s3v_ff <= s2v_ff;
         if (load_rsp) begin
            have_pair_ff <= 1'b0;
         end else if (s3v_ff) begin
            have_pair_ff <= 1'b1;
         end
      end
   end

   // Pipe payload and best pairs
   always_ff @(posedge clock) begin
      ri_ff <= rd_ff;
      if (rdv_ff) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         qx2_ff <= rqx;
         qy2_ff <= rqy;
         i2_ff  <= ri_ff;
      end
      if (s2v_ff) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         qx3_ff <= qx2_ff;
         qy3_ff <= qy2_ff;
         i3_ff  <= i2_ff;
      end
      if (take_far) begin
         fd_ff  <= dist_sq;
         fa_ff  <= i3_ff;
         fax_ff <= qx3_ff;
         fay_ff <= qy3_ff;
         fbx_ff <= px_ff;
         fby_ff <= py_ff;
      end
      if (take_near) begin
         nd_ff  <= dist_sq;
         na_ff  <= i3_ff;
         nax_ff <= qx3_ff;
         nay_ff <= qy3_ff;
         nbx_ff <= px_ff;
         nby_ff <= py_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_far_dist_sq  = rsp_far_dist_ff;
   assign rsp_far_ax       = rsp_far_ax_ff;
   assign rsp_far_ay       = rsp_far_ay_ff;
   assign rsp_far_bx       = rsp_far_bx_ff;
   assign rsp_far_by       = rsp_far_by_ff;
   assign rsp_near_dist_sq = rsp_near_dist_ff;
   assign rsp_near_ax      = rsp_near_ax_ff;
   assign rsp_near_ay      = rsp_near_ay_ff;
   assign rsp_near_bx      = rsp_near_bx_ff;
   assign rsp_near_by      = rsp_near_by_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ----- src/closest_farthest_pair_finder_core.sv -----
// Top level of the closest and farthest pair finder: front, queue and back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Carries
// req_      in         req_valid/req_ready    one point, last_point marks the end of a set
// rsp_      out        rsp_valid/rsp_ready    farthest and closest pair, distances, status
//
// For each point the back sweeps every point stored before it through the distance pipe,
// then drains that pipe; a last point also loads the result register.
// The rate is set by the single distance pipe fed from one store read port, one pair a cycle.
// A four-entry queue lets the front keep taking requests while the back sweeps or the
// result waits. Reset is synchronous; the point store needs no clearing pass.

module closest_farthest_pair_finder_core #(
   parameter int MAX_POINTS = cfp_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = cfp_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [cfp_pkg::IN_COORD_W-1:0]  req_coord_x,
   input  logic signed [cfp_pkg::IN_COORD_W-1:0]  req_coord_y,
   input  logic                                   req_last_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [cfp_pkg::DIST_OUT_W-1:0]         rsp_far_dist_sq,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_ax,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_ay,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_bx,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_by,
   output logic [cfp_pkg::DIST_OUT_W-1:0]         rsp_near_dist_sq,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_ax,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_ay,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_bx,
   output logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_by,
   output logic [cfp_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CTRL_W = $bits(cfp_pkg::item_ctrl_type);
   localparam int ENT_W  = CTRL_W + IDX_W + 2 * COORD_BITS;
   localparam int DIST_W = 2 * COORD_BITS + 1;

   logic                   push_valid, push_ready;
   cfp_pkg::item_ctrl_type push_ctrl;
   logic [IDX_W-1:0]       push_idx;
   logic [COORD_BITS-1:0]  push_x, push_y;
   logic                   pop_valid, pop_ready;
   logic [ENT_W-1:0]       pop_data;
   cfp_pkg::item_ctrl_type pop_ctrl;
   logic [IDX_W-1:0]       pop_idx;
   logic [COORD_BITS-1:0]  pop_x, pop_y;
   cfp_pkg::status_type    back_status;

   cfp_front #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_last_point (req_last_point),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_ctrl      (push_ctrl),
      .push_idx       (push_idx),
      .push_x         (push_x),
      .push_y         (push_y)
   );

   cfp_queue #(
      .WIDTH (ENT_W),
      .DEPTH (cfp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_ctrl, push_idx, push_x, push_y}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Unpack the queue head
   assign pop_ctrl = cfp_pkg::item_ctrl_type'(pop_data[ENT_W-1 -: CTRL_W]);
   assign pop_idx  = pop_data[2*COORD_BITS +: IDX_W];
   assign pop_x    = pop_data[COORD_BITS +: COORD_BITS];
   assign pop_y    = pop_data[COORD_BITS-1:0];

   cfp_back #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (pop_valid),
      .q_ready          (pop_ready),
      .q_ctrl           (pop_ctrl),
      .q_idx            (pop_idx),
      .q_x              (pop_x),
      .q_y              (pop_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_far_dist_sq  (rsp_far_dist_sq),
      .rsp_far_ax       (rsp_far_ax),
      .rsp_far_ay       (rsp_far_ay),
      .rsp_far_bx       (rsp_far_bx),
      .rsp_far_by       (rsp_far_by),
      .rsp_near_dist_sq (rsp_near_dist_sq),
      .rsp_near_ax      (rsp_near_ax),
      .rsp_near_ay      (rsp_near_ay),
      .rsp_near_bx      (rsp_near_bx),
      .rsp_near_by      (rsp_near_by),
      .rsp_status       (back_status)
   );

   assign rsp_status = back_status;

   // A result only ever carries one of the defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == cfp_pkg::STATUS_OK) ||
                    (rsp_status == cfp_pkg::STATUS_FEW) ||
                    (rsp_status == cfp_pkg::STATUS_DROP))
      else $error("undefined status on result");

   // A set with fewer than two points reports all-zero distances
   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cfp_pkg::STATUS_FEW)) |->
         (rsp_far_dist_sq == '0) && (rsp_near_dist_sq == '0))
      else $error("distances not cleared on short set");

   // The closest pair is never farther apart than the farthest one
   a_near_le_far: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != cfp_pkg::STATUS_FEW) &&
       (DIST_W <= cfp_pkg::DIST_OUT_W)) |-> (rsp_near_dist_sq <= rsp_far_dist_sq))
      else $error("closest pair farther than farthest pair");

   // The back never takes a queue entry while its result is still waiting
   a_no_pop_on_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> !$past(pop_valid && pop_ready))
      else $error("queue popped while result pending");

endmodule

// ----- tb/pair_finder_checker.sv -----
// Checker for the pair finder: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module pair_finder_checker #(
   parameter int MAX_POINTS = cfp_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = cfp_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [cfp_pkg::IN_COORD_W-1:0]  req_coord_x,
   input  logic signed [cfp_pkg::IN_COORD_W-1:0]  req_coord_y,
   input  logic                                   req_last_point,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [cfp_pkg::DIST_OUT_W-1:0]         rsp_far_dist_sq,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_ax,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_ay,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_bx,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_far_by,
   input  logic [cfp_pkg::DIST_OUT_W-1:0]         rsp_near_dist_sq,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_ax,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_ay,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_bx,
   input  logic signed [cfp_pkg::OUT_COORD_W-1:0] rsp_near_by,
   input  logic [cfp_pkg::STATUS_W-1:0]           rsp_status,
   output int                                     mismatch_count,
   output int                                     results_pending
);
   import cfp_pkg::*;

   typedef struct {
      logic [DIST_OUT_W-1:0]         far_dist_sq;
      logic signed [OUT_COORD_W-1:0] far_ax;
      logic signed [OUT_COORD_W-1:0] far_ay;
      logic signed [OUT_COORD_W-1:0] far_bx;
      logic signed [OUT_COORD_W-1:0] far_by;
      logic [DIST_OUT_W-1:0]         near_dist_sq;
      logic signed [OUT_COORD_W-1:0] near_ax;
      logic signed [OUT_COORD_W-1:0] near_ay;
      logic signed [OUT_COORD_W-1:0] near_bx;
      logic signed [OUT_COORD_W-1:0] near_by;
      status_type                    status;
   } pair_result_type;

   // Results owed by the block, oldest first
   pair_result_type expected_pairs[$];

   // Our own copy of the current point set
   longint kept_x [MAX_POINTS];
   longint kept_y [MAX_POINTS];
   int     kept_count;
   logic   overflowed;
   int     result_number;

   // Low COORD_BITS of the field, sign-extended
   function automatic longint narrow_coord(logic [IN_COORD_W-1:0] raw);
      longint v;
      v = longint'(raw) & ((longint'(1) << COORD_BITS) - 1);
      if (v[COORD_BITS-1]) begin
         v -= longint'(1) << COORD_BITS;
      end
      return v;
   endfunction

   function automatic longint span_sq(int a, int b);
      longint dx, dy;
      dx = kept_x[a] - kept_x[b];
      dy = kept_y[a] - kept_y[b];
      return dx * dx + dy * dy;
   endfunction

   // Sweep every pair in row order; only a strict improvement replaces the best,
   // so the earliest pair wins a tie
   function automatic pair_result_type closest_and_farthest();
      pair_result_type r;
      int     fa, fb, na, nb;
      longint fd, nd, d;
      r = '{default: 0};
      if (kept_count < 2) begin
         r.status = STATUS_FEW;
         return r;
      end
      fa = 0;
      fb = 1;
      na = 0;
      nb = 1;
      fd = span_sq(0, 1);
      nd = fd;
      for (int i = 0; i < kept_count; i++) begin
         for (int j = i + 1; j < kept_count; j++) begin
            d = span_sq(i, j);
            if (d > fd) begin
               fd = d;
               fa = i;
               fb = j;
            end
            if (d < nd) begin
               nd = d;
               na = i;
               nb = j;
            end
         end
      end
      r.far_dist_sq  = fd[DIST_OUT_W-1:0];
      r.far_ax       = kept_x[fa][OUT_COORD_W-1:0];
      r.far_ay       = kept_y[fa][OUT_COORD_W-1:0];
      r.far_bx       = kept_x[fb][OUT_COORD_W-1:0];
      r.far_by       = kept_y[fb][OUT_COORD_W-1:0];
      r.near_dist_sq = nd[DIST_OUT_W-1:0];
      r.near_ax      = kept_x[na][OUT_COORD_W-1:0];
      r.near_ay      = kept_y[na][OUT_COORD_W-1:0];
      r.near_bx      = kept_x[nb][OUT_COORD_W-1:0];
      r.near_by      = kept_y[nb][OUT_COORD_W-1:0];
      r.status       = overflowed ? STATUS_DROP : STATUS_OK;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   result_number, field, got, want));
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      pair_result_type want;
      if (reset) begin
         expected_pairs.delete();
         kept_count = 0;
         overflowed = 1'b0;
      end else begin
         // Result side first: a result can never belong to a request taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch("result arrived with none expected");
            end else begin
               want = expected_pairs.pop_front();
               check_field("far_dist_sq", rsp_far_dist_sq, want.far_dist_sq);
               check_field("far_ax", rsp_far_ax, want.far_ax);
               check_field("far_ay", rsp_far_ay, want.far_ay);
               check_field("far_bx", rsp_far_bx, want.far_bx);
               check_field("far_by", rsp_far_by, want.far_by);
               check_field("near_dist_sq", rsp_near_dist_sq, want.near_dist_sq);
               check_field("near_ax", rsp_near_ax, want.near_ax);
               check_field("near_ay", rsp_near_ay, want.near_ay);
               check_field("near_bx", rsp_near_bx, want.near_bx);
               check_field("near_by", rsp_near_by, want.near_by);
               check_field("status", rsp_status, want.status);
            end
            result_number++;
         end
         // Request side: store or drop the point, analyse on the last one
         if (req_valid && req_ready) begin
            if (kept_count < MAX_POINTS) begin
               kept_x[kept_count] = narrow_coord(req_coord_x);
               kept_y[kept_count] = narrow_coord(req_coord_y);
               kept_count++;
            end else begin
               overflowed = 1'b1;
            end
            if (req_last_point) begin
               expected_pairs.push_back(closest_and_farthest());
               kept_count = 0;
               overflowed = 1'b0;
            end
         end
      end
      results_pending = expected_pairs.size();
   end

endmodule

// ----- tb/closest_farthest_pair_finder_core_test.sv -----
// Top of the pair finder testbench: clock, reset, point stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module closest_farthest_pair_finder_core_test;
   import cfp_pkg::*;

   localparam int MAX_POINTS   = MAX_POINTS_DEF;
   localparam int COORD_BITS   = COORD_BITS_DEF;
   localparam int RANDOM_ITEMS = 2000;
   // Slowest correct run: roughly 2000 requests, each swept against up to MAX_POINTS stored
   // points, plus sender gaps and result stalls; several times that for margin
   localparam longint RUN_LIMIT = 3_000_000;
   // Window of cycles in which neither side idles
   localparam longint QUIET_FROM = 20_000;
   localparam longint QUIET_TO   = 45_000;

   localparam logic signed [IN_COORD_W-1:0] COORD_MIN = 16'sh8000;
   localparam logic signed [IN_COORD_W-1:0] COORD_MAX = 16'sh7FFF;

   typedef enum {SPREAD_FULL, SPREAD_TINY, SPREAD_EDGE} spread_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_COORD_W-1:0] req_coord_x = '0;
   logic signed [IN_COORD_W-1:0] req_coord_y = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DIST_OUT_W-1:0]         rsp_far_dist_sq;
   logic signed [OUT_COORD_W-1:0] rsp_far_ax, rsp_far_ay, rsp_far_bx, rsp_far_by;
   logic [DIST_OUT_W-1:0]         rsp_near_dist_sq;
   logic signed [OUT_COORD_W-1:0] rsp_near_ax, rsp_near_ay, rsp_near_bx, rsp_near_by;
   logic [STATUS_W-1:0]           rsp_status;
   int mismatch_count;
   int results_pending;
   longint cycle_count = 0;

   closest_farthest_pair_finder_core #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_far_dist_sq(rsp_far_dist_sq),
      .rsp_far_ax(rsp_far_ax),
      .rsp_far_ay(rsp_far_ay),
      .rsp_far_bx(rsp_far_bx),
      .rsp_far_by(rsp_far_by),
      .rsp_near_dist_sq(rsp_near_dist_sq),
      .rsp_near_ax(rsp_near_ax),
      .rsp_near_ay(rsp_near_ay),
      .rsp_near_bx(rsp_near_bx),
      .rsp_near_by(rsp_near_by),
      .rsp_status(rsp_status)
   );

   pair_finder_checker #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_far_dist_sq(rsp_far_dist_sq),
      .rsp_far_ax(rsp_far_ax),
      .rsp_far_ay(rsp_far_ay),
      .rsp_far_bx(rsp_far_bx),
      .rsp_far_by(rsp_far_by),
      .rsp_near_dist_sq(rsp_near_dist_sq),
      .rsp_near_ax(rsp_near_ax),
      .rsp_near_ay(rsp_near_ay),
      .rsp_near_bx(rsp_near_bx),
      .rsp_near_by(rsp_near_by),
      .rsp_status(rsp_status),
      .mismatch_count(mismatch_count),
      .results_pending(results_pending)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("FAIL closest_farthest_pair_finder_core");
         $finish;
      end
   end

   function automatic logic no_idling();
      return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
   endfunction

   // Result side stalls at random, with a chance of about ten percent
   always @(negedge clock) begin
      rsp_ready <= no_idling() || ($urandom_range(0, 99) >= 10);
   end

   function automatic logic signed [IN_COORD_W-1:0] pick_coord(spread_type spread);
      int v;
      case (spread)
         SPREAD_TINY: begin
            v = int'($urandom_range(0, 6)) - 3;
         end
         SPREAD_EDGE: begin
            case ($urandom_range(0, 6))
               0: v = -32768;
               1: v = -32767;
               2: v = -1;
               3: v = 0;
               4: v = 1;
               5: v = 32766;
               default: v = 32767;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 65535)) - 32768;
         end
      endcase
      return v[IN_COORD_W-1:0];
   endfunction

   // Mostly small sets, now and then a medium one
   function automatic int random_set_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return 1;
      if (roll < 70) return $urandom_range(2, 8);
      if (roll < 95) return $urandom_range(9, 40);
      return $urandom_range(41, 120);
   endfunction

   // One request; idle cycles in front carry junk payload with valid low
   task automatic send_point(input logic signed [IN_COORD_W-1:0] x,
                             input logic signed [IN_COORD_W-1:0] y,
                             input logic last);
      @(negedge clock);
      while (!no_idling() && $urandom_range(0, 99) < 10) begin
         req_valid      <= 1'b0;
         req_coord_x    <= pick_coord(SPREAD_FULL);
         req_coord_y    <= pick_coord(SPREAD_FULL);
         req_last_point <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_coord_x    <= x;
      req_coord_y    <= y;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off the sender until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   initial begin
      int sent;
      int set_index;
      int set_size;
      spread_type spread;
      int roll;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Single point: too few for a pair
      send_point(COORD_MIN, COORD_MAX, 1'b1);
      // Opposite corners: largest possible distance
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b1);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);
      // Closest tie between pairs (0,3) and (1,2): the earlier row must win
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd3, 1'b0);
      send_point(16'sd0, 16'sd3, 1'b1);
      // Farthest tie between pairs (0,3) and (1,2), all other pairs equal
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd2, 16'sd2, 1'b0);
      send_point(16'sd2, -16'sd2, 1'b0);
      send_point(16'sd4, 16'sd0, 1'b1);
      // Coincident points
      send_point(16'sd5, -16'sd5, 1'b0);
      send_point(16'sd5, -16'sd5, 1'b1);
      send_point(-16'sd1, -16'sd1, 1'b0);
      send_point(COORD_MAX, 16'sd0, 1'b0);
      send_point(16'sd0, COORD_MIN, 1'b0);
      send_point(-16'sd1, -16'sd1, 1'b1);
      drain_results();

      // Random sets, with full, just-over and well-over capacity sets mixed in
      sent = 0;
      set_index = 0;
      while (sent < RANDOM_ITEMS) begin
         case (set_index)
            3:       set_size = MAX_POINTS;
            12:      set_size = MAX_POINTS + 1;
            30:      set_size = MAX_POINTS + 6;
            default: set_size = random_set_size();
         endcase
         roll = $urandom_range(0, 9);
         spread = roll < 5 ? SPREAD_FULL : (roll < 8 ? SPREAD_TINY : SPREAD_EDGE);
         for (int k = 0; k < set_size; k++) begin
            send_point(pick_coord(spread), pick_coord(spread), k == set_size - 1);
         end
         sent += set_size;
         set_index++;
         if (set_index == 20) begin
            drain_results();
         end
      end

      // Wind down: all results in, then a tail long enough for one full sweep
      drain_results();
      repeat (MAX_POINTS + 16) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("PASS closest_farthest_pair_finder_core");
      end else begin
         $display("FAIL closest_farthest_pair_finder_core");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/cfp_pkg.sv
src/cfp_ram.sv
src/cfp_queue.sv
src/cfp_front.sv
src/cfp_back.sv
src/closest_farthest_pair_finder_core.sv
tb/pair_finder_checker.sv
tb/closest_farthest_pair_finder_core_test.sv
